@@ sv/bph_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bph_pkg
// shared types and constants of the bit pattern histogram unit
// ---------------------------------------------------------------------------
package bph_pkg;

   // default sizes
   localparam int MAX_PATTERN_LEN_DEF = 12;
   localparam int COUNT_BITS_DEF      = 24;

   // fixed field widths
   localparam int LEN_REG_W   = 4;
   localparam int QLEN_W      = 4;
   localparam int QPAT_W      = 12;
   localparam int REQ_TDATA_W = 24;
   localparam int CSR_IDX_W   = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LEN = 1'b1;

   // register reset values
   localparam logic [LEN_REG_W-1:0] MIN_LEN_RST = 4'd1;
   localparam logic [LEN_REG_W-1:0] MAX_LEN_RST = 4'd12;

   // command codes carried in tuser
   localparam logic CMD_SHIFT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_QUERY
   } state_type;

endpackage
`default_nettype wire

@@ sv/bph_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bph_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module bph_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

@@ sv/bit_pattern_histogram_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bit_pattern_histogram_unit
// overlapping bit n-gram histogram of a serial bit stream
// ---------------------------------------------------------------------------
// A shift word (tuser 0) moves one stream bit into the history; the count of
// the newest pattern of every length in min_len..max_len that the bits seen so
// far cover is then incremented, saturating at all ones. A read word (tuser 1)
// returns one word with the stored count of a length and pattern and a flag
// saying whether that length is currently counted. All counts live in one
// memory of 2^(MAX_PATTERN_LEN+1) entries, addressed by 2^len + pattern, with
// one read and one write port. A shift is accepted, then each counted length
// gets one read-modify-write through the memory read port, each write
// following its read in the next cycle; a read waits in the query state
// until the result side is free. After reset the memory is swept to zero, one
// entry per cycle, over all 2^(MAX_PATTERN_LEN+1) entries (8192 at the default
// size); no word is accepted meanwhile, csr writes are taken throughout.
// ---------------------------------------------------------------------------
module bit_pattern_histogram_unit
   import bph_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // bit_in [0], query_len [4:1], query_pattern [16:5], zero above
   input  wire logic [REQ_TDATA_W-1:0]            req_tdata,
   // command [0]
   input  wire logic                              req_tuser,
   // response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // occurrences [COUNT_BITS-1:0], in_range [COUNT_BITS], zero above
   output logic [((COUNT_BITS+8)/8)*8-1:0]        rsp_tdata,
   // register write port
   input  wire logic                              csr_we,
   input  wire logic [CSR_IDX_W-1:0]              csr_index,
   input  wire logic [LEN_REG_W-1:0]              csr_wdata
);

   localparam int HW    = MAX_PATTERN_LEN;
   localparam int AW    = MAX_PATTERN_LEN + 1;
   localparam int DEPTH = 2 ** AW;
   localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
   localparam int CMP_W = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
   localparam int RSP_W = ((COUNT_BITS + 8) / 8) * 8;

   // control state
   state_type              state_ff, state_in;
   logic [LEN_REG_W-1:0]   min_len_ff, min_len_in;
   logic [LEN_REG_W-1:0]   max_len_ff, max_len_in;
   logic [HW-1:0]          history_ff, history_in;
   logic [LEN_W-1:0]       bits_seen_ff, bits_seen_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic                   wr_pend_ff, wr_pend_in;
   logic                   fwd_ff, fwd_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload
   logic [AW-1:0]          wr_addr_ff;
   logic [COUNT_BITS-1:0]  fwd_data_ff;
   logic                   query_ok_ff, query_ok_in;
   logic                   in_range_ff, in_range_in;
   logic [COUNT_BITS-1:0]  rsp_occ_ff;
   logic                   rsp_inr_ff;

   // memory ports
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [COUNT_BITS-1:0]  ram_wdata;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr;
   logic [COUNT_BITS-1:0]  ram_rdata;

   logic                   req_accept;
   logic                   rsp_free;
   logic                   rsp_load;
   logic                   scan_counted;
   logic [HW-1:0]          scan_mask;
   logic [AW-1:0]          scan_addr;
   logic                   q_bit;
   logic [QLEN_W-1:0]      q_len;
   logic [QPAT_W-1:0]      q_pat;
   logic                   q_len_ok;
   logic [AW-1:0]          q_addr;
   logic [COUNT_BITS-1:0]  rd_count;
   logic [COUNT_BITS-1:0]  inc_count;

   // field unpacking
   assign q_bit = req_tdata[0];
   assign q_len = req_tdata[4:1];
   assign q_pat = req_tdata[16:5];

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // query decode: length must name a stored bank, pattern must fit the length
   assign q_len_ok    = (q_len != '0) && (CMP_W'(q_len) <= CMP_W'(MAX_PATTERN_LEN));
   assign query_ok_in = q_len_ok && ((q_pat >> q_len) == '0);
   assign in_range_in = q_len_ok && (CMP_W'(q_len) >= CMP_W'(min_len_ff))
                        && (CMP_W'(q_len) <= CMP_W'(max_len_ff));
   assign q_addr      = (AW'(1) << q_len) | AW'(q_pat);

   // scan address: bank marker bit above the newest len bits of history
   assign scan_mask    = (HW'(1) << len_ff) - HW'(1);
   assign scan_addr    = (AW'(1) << len_ff) | AW'(history_ff & scan_mask);
   assign scan_counted = (CMP_W'(len_ff) >= CMP_W'(min_len_ff))
                         && (CMP_W'(len_ff) <= CMP_W'(max_len_ff))
                         && (CMP_W'(len_ff) <= CMP_W'(bits_seen_ff));

   // read data, forwarded when the read hit the entry written in the same cycle
   assign rd_count  = fwd_ff ? fwd_data_ff : ram_rdata;
   assign inc_count = (&rd_count) ? rd_count : rd_count + COUNT_BITS'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == CMD_READ) ? ST_QUERY : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (len_ff == LEN_W'(MAX_PATTERN_LEN)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_tready   = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = scan_addr;
      wr_pend_in   = 1'b0;
      rsp_load     = 1'b0;
      clr_addr_in  = clr_addr_ff;
      len_in       = len_ff;
      history_in   = history_ff;
      bits_seen_in = bits_seen_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            len_in     = LEN_W'(1);
            if (req_accept && (req_tuser == CMD_READ)) begin
               ram_re    = 1'b1;
               ram_raddr = q_addr;
            end else if (req_accept) begin
               history_in = (history_ff << 1) | HW'(q_bit);
               if (CMP_W'(bits_seen_ff) < CMP_W'(MAX_PATTERN_LEN)) begin
                  bits_seen_in = bits_seen_ff + LEN_W'(1);
               end
            end
         end
         ST_SCAN: begin
            ram_re     = scan_counted;
            wr_pend_in = scan_counted;
            len_in     = len_ff + LEN_W'(1);
         end
         ST_QUERY: begin
            rsp_load = rsp_free;
         end
         default: begin
            clr_addr_in = clr_addr_ff;
         end
      endcase
   end

   // write port: zero sweep after reset, else the trailing increment
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = wr_pend_ff;
         ram_waddr = wr_addr_ff;
         ram_wdata = inc_count;
      end
   end

   assign fwd_in = ram_we && (ram_waddr == ram_raddr);

   // register file
   always_comb begin
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MIN_LEN: min_len_in = csr_wdata;
            REG_MAX_LEN: max_len_in = csr_wdata;
            default:     min_len_in = min_len_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         min_len_ff   <= MIN_LEN_RST;
         max_len_ff   <= MAX_LEN_RST;
         history_ff   <= '0;
         bits_seen_ff <= '0;
         len_ff       <= LEN_W'(1);
         clr_addr_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_len_ff   <= min_len_in;
         max_len_ff   <= max_len_in;
         history_ff   <= history_in;
         bits_seen_ff <= bits_seen_in;
         len_ff       <= len_in;
         clr_addr_ff  <= clr_addr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_re) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         wr_addr_ff  <= ram_raddr;
         fwd_data_ff <= ram_wdata;
      end
      if (req_accept) begin
         query_ok_ff <= query_ok_in;
         in_range_ff <= in_range_in;
      end
      if (rsp_load) begin
         rsp_occ_ff <= query_ok_ff ? rd_count : '0;
         rsp_inr_ff <= in_range_ff;
      end
   end

   bph_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_inr_ff, rsp_occ_ff});

   // nothing is taken in while the count memory is being swept
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing sweep");

   // lengths of one scan sit in distinct banks, so a scan never needs forwarding
   a_scan_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && ram_re && wr_pend_ff) |-> (ram_raddr != wr_addr_ff))
      else $error("scan read hit the entry being written");

   // an increment only ever follows a scan read
   a_write_after_scan: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(state_ff == ST_SCAN))
      else $error("count write without a scan read");

   // bits seen saturates at the longest pattern length
   a_bits_seen_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(bits_seen_ff) <= CMP_W'(MAX_PATTERN_LEN))
      else $error("bits seen beyond the longest pattern");

endmodule
`default_nettype wire

@@ test/bit_pattern_histogram_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bit_pattern_histogram_unit_tb
// self-checking bench for the bit pattern histogram unit
// ---------------------------------------------------------------------------
// A short directed table is followed by random shift and read words across a
// series of length ranges. The ranges include empty ones and ones reaching
// past the legal lengths. The bench keeps its own history, fill level and
// count store. Every read word without a reply typed into the directed table
// is predicted from that copy, and each response is compared field by field
// in arrival order. Idle gaps fall on both streams.
// ---------------------------------------------------------------------------
module bit_pattern_histogram_unit_tb;
   import bph_pkg::*;

   localparam int RSP_TDATA_W    = ((COUNT_BITS_DEF + 8) / 8) * 8;
   localparam int STORE_DEPTH    = 2 << MAX_PATTERN_LEN_DEF;
   localparam int SHIFT_SETTLE   = MAX_PATTERN_LEN_DEF + 8;   // one shift plus margin
   localparam int DRAIN_LIMIT    = 5000;
   localparam int RAND_PER_PHASE = 70;
   localparam int NUM_PHASES     = 9;
   localparam int NUM_ROWS       = 23;
   localparam logic [COUNT_BITS_DEF-1:0] COUNT_SAT = '1;

   typedef struct packed {
      logic [COUNT_BITS_DEF-1:0] occurrences;
      logic                      in_range;
   } count_reply_type;

   typedef struct packed {
      logic              command;
      logic              stream_bit;
      logic [QLEN_W-1:0] query_len;
      logic [QPAT_W-1:0] query_pattern;
      logic              fixed;          // reply typed in below
      count_reply_type   reply;
   } table_row_type;

   // directed words: empty store reads, illegal lengths, a filled history, wide patterns
   localparam table_row_type DIRECTED [NUM_ROWS] = '{
      '{CMD_READ,  1'b0, 4'd1,  12'd0,    1'b1, '{24'd0, 1'b1}},
      '{CMD_READ,  1'b0, 4'd12, 12'd4095, 1'b1, '{24'd0, 1'b1}},
      '{CMD_READ,  1'b1, 4'd0,  12'd0,    1'b1, '{24'd0, 1'b0}},
      '{CMD_READ,  1'b0, 4'd15, 12'd4095, 1'b1, '{24'd0, 1'b0}},
      '{CMD_READ,  1'b1, 4'd13, 12'd0,    1'b1, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd15, 12'd4095, 1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b0, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b0, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b0, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b0, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b1, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_SHIFT, 1'b0, 4'd0,  12'd0,    1'b0, '{24'd0, 1'b0}},
      '{CMD_READ,  1'b0, 4'd1,  12'd1,    1'b0, '{24'd0, 1'b0}},
      '{CMD_READ,  1'b0, 4'd2,  12'd3,    1'b0, '{24'd0, 1'b0}},
      '{CMD_READ,  1'b0, 4'd12, 12'hA76,  1'b0, '{24'd0, 1'b0}},
      '{CMD_READ,  1'b0, 4'd3,  12'd8,    1'b1, '{24'd0, 1'b1}},
      '{CMD_READ,  1'b1, 4'd0,  12'd1,    1'b1, '{24'd0, 1'b0}}
   };

   // length ranges per phase: normal, narrow, single, empty and out-of-range
   localparam logic [LEN_REG_W-1:0] PHASE_LO [NUM_PHASES] = '{1, 3, 12, 1, 9, 0, 0, 15, 5};
   localparam logic [LEN_REG_W-1:0] PHASE_HI [NUM_PHASES] = '{12, 7, 12, 1, 4, 15, 0, 15, 12};

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_W-1:0]     req_tdata  = '0;
   logic                       req_tuser  = CMD_SHIFT;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]     rsp_tdata;
   logic                       csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index  = REG_MIN_LEN;
   logic [LEN_REG_W-1:0]       csr_wdata  = '0;

   // idle rates in percent
   int unsigned send_idle_pct = 17;
   int unsigned stall_pct     = 53;

   int errors    = 0;
   int n_shifts  = 0;
   int n_reads   = 0;
   int n_hits    = 0;
   int n_checked = 0;

   // local copy of the block state
   logic [MAX_PATTERN_LEN_DEF-1:0] hist_bits;
   int unsigned                    bits_taken;
   logic [COUNT_BITS_DEF-1:0]      pattern_tally [STORE_DEPTH];
   logic [LEN_REG_W-1:0]           len_lo;
   logic [LEN_REG_W-1:0]           len_hi;

   // read replies still owed by the block, oldest first
   count_reply_type pending_counts [$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bit_pattern_histogram_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic bit length_counted(int unsigned len);
      return len >= 1 && len <= MAX_PATTERN_LEN_DEF && len >= len_lo && len <= len_hi;
   endfunction

   // newest bit enters at the bottom, then every covered length in range counts its pattern
   function automatic void apply_shift(logic stream_bit);
      int unsigned idx;
      hist_bits = {hist_bits[MAX_PATTERN_LEN_DEF-2:0], stream_bit};
      if (bits_taken < MAX_PATTERN_LEN_DEF) bits_taken++;
      for (int len = 1; len <= MAX_PATTERN_LEN_DEF; len++) begin
         if (length_counted(len) && len <= bits_taken) begin
            idx = (1 << len) + (hist_bits & ((1 << len) - 1));
            if (pattern_tally[idx] != COUNT_SAT) pattern_tally[idx]++;
         end
      end
   endfunction

   function automatic count_reply_type lookup_count(logic [QLEN_W-1:0] qlen,
                                                    logic [QPAT_W-1:0] qpat);
      count_reply_type r;
      r = '0;
      if (qlen >= 1 && qlen <= MAX_PATTERN_LEN_DEF) begin
         // bits at or above the length name no pattern
         if ((32'(qpat) >> qlen) == 0) r.occurrences = pattern_tally[(1 << qlen) + qpat];
         r.in_range = length_counted(qlen);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // one word onto the request stream, with optional idle cycles in front
   task automatic put_word(logic cmd, logic stream_bit, logic [QLEN_W-1:0] qlen,
                           logic [QPAT_W-1:0] qpat, logic fixed,
                           count_reply_type fixed_reply);
      count_reply_type reply;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_TDATA_W'({qpat, qlen, stream_bit});
      do @(posedge clock); while (req_tready !== 1'b1);
      if (cmd == CMD_SHIFT) begin
         apply_shift(stream_bit);
         n_shifts++;
      end else begin
         reply = fixed ? fixed_reply : lookup_count(qlen, qpat);
         pending_counts.insert(pending_counts.size(), reply);
         n_reads++;
         if (reply.occurrences != 0) n_hits++;
      end
      @(negedge clock);
   endtask

   // sender holds off until every read reply is back
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_counts.size() != 0) @(negedge clock);
   endtask

   // registers only change with the block idle, a shift may still be running
   task automatic set_lengths(logic [LEN_REG_W-1:0] lo, logic [LEN_REG_W-1:0] hi);
      hold_until_drained();
      repeat (SHIFT_SETTLE) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_MIN_LEN;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= REG_MAX_LEN;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we <= 1'b0;
      len_lo = lo;
      len_hi = hi;
      @(negedge clock);
   endtask

   // receiver back-pressure
   always @(negedge clock)
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

   // response checker, sampled at the rising edge
   always @(posedge clock) begin : check_response
      count_reply_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("response word with no read outstanding", rsp_tdata, 0);
         end else begin
            want = pending_counts.pop_front();
            n_checked++;
            if (rsp_tdata[COUNT_BITS_DEF-1:0] !== want.occurrences)
               report_mismatch("occurrences", rsp_tdata[COUNT_BITS_DEF-1:0], want.occurrences);
            if (rsp_tdata[COUNT_BITS_DEF] !== want.in_range)
               report_mismatch("in_range", rsp_tdata[COUNT_BITS_DEF], want.in_range);
         end
      end
   end

   // main sequence
   initial begin : stimulus
      int unsigned       roll;
      int                waited;
      logic [QLEN_W-1:0] qlen;
      logic [QPAT_W-1:0] qpat;

      hist_bits  = '0;
      bits_taken = 0;
      len_lo     = MIN_LEN_RST;
      len_hi     = MAX_LEN_RST;
      for (int i = 0; i < STORE_DEPTH; i++) pattern_tally[i] = '0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, reset length range; the clearing sweep holds off the first word
      foreach (DIRECTED[i])
         put_word(DIRECTED[i].command, DIRECTED[i].stream_bit, DIRECTED[i].query_len,
                  DIRECTED[i].query_pattern, DIRECTED[i].fixed, DIRECTED[i].reply);

      // random phases, history and counts carry across each range change
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_lengths(PHASE_LO[ph], PHASE_HI[ph]);
         if (ph < 3) begin
            send_idle_pct = 17;
            stall_pct     = 53;
         end else if (ph < 6) begin
            send_idle_pct = 53;
            stall_pct     = 17;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if ((ph == 1 || ph == 4) && n == RAND_PER_PHASE / 2) hold_until_drained();
            roll = $urandom_range(99);
            qlen = QLEN_W'($urandom_range(MAX_PATTERN_LEN_DEF, 1));
            qpat = QPAT_W'(hist_bits & ((1 << qlen) - 1));
            if (roll < 55) begin
               // shift with junk in the unused fields
               put_word(CMD_SHIFT, 1'($urandom_range(1)), QLEN_W'($urandom_range(15)),
                        QPAT_W'($urandom), 1'b0, '0);
            end else if (roll < 80) begin
               // newest pattern, certain to be counted when in range
               put_word(CMD_READ, 1'($urandom_range(1)), qlen, qpat, 1'b0, '0);
            end else if (roll < 92) begin
               qpat = QPAT_W'($urandom_range((1 << qlen) - 1));
               put_word(CMD_READ, 1'($urandom_range(1)), qlen, qpat, 1'b0, '0);
            end else begin
               // any length, any pattern: illegal lengths and wide patterns
               put_word(CMD_READ, 1'($urandom_range(1)), QLEN_W'($urandom_range(15)),
                        QPAT_W'($urandom), 1'b0, '0);
            end
         end
      end

      // drain, then let a trailing shift finish
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_counts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SHIFT_SETTLE) @(negedge clock);
      if (pending_counts.size() != 0)
         report_mismatch("read replies never returned", pending_counts.size(), 0);

      $display("covered %0d shifted bits and %0d read words over %0d length ranges",
               n_shifts, n_reads, NUM_PHASES + 1);
      $display("%0d replies checked, %0d of them with a nonzero count", n_checked, n_hits);
      if (errors == 0) begin
         $display("bit_pattern_histogram_unit: match");
      end else begin
         $display("bit_pattern_histogram_unit: mismatch");
      end
      $finish;
   end

   // run limit, far above the clearing sweep plus the slowest legal run
   initial begin
      #4_800_000;
      $display("bit_pattern_histogram_unit: mismatch");
      $finish;
   end

endmodule
